// ===== rtl/core/trd_pkg.sv =====
`default_nettype none

package trd_pkg;

  // Command kinds carried on the result channel.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_COPY  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // Byte that arms copy-previous-column mode.
  localparam logic [7:0] COPY_CODE = 8'h01;
  // Bit of an even byte that asks for the byte to be written twice.
  localparam int unsigned DOUBLE_BIT = 4;
  // Bias added to the halved run header.
  localparam logic [7:0] RUN_BIAS = 8'd2;
  // Width of a position column value as reported (column counter at most 256).
  localparam int unsigned CUR_COL_W = 9;
  // Width of row plus fill length (127 + 255 fits).
  localparam int unsigned FILL_SUM_W = 9;
  // Width of column plus copy count (256 + 255 fits).
  localparam int unsigned COPY_SUM_W = 10;

  // One input item held in the input register.
  typedef struct packed {
    logic       mode;
    logic [7:0] code_byte;
  } item_t;

  // One write command.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] column;
    logic [6:0] row;
    logic [7:0] length;
    logic [7:0] fill_value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/trd_in_reg.sv =====
`default_nettype none

// Input register: holds one accepted item until the decode stage takes it.
module trd_in_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire trd_pkg::item_t item_i,
  output logic                valid_o,
  input  wire                 take_i,
  output trd_pkg::item_t      item_o
);

  logic           valid_q, valid_d;
  trd_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/trd_core.sv =====
`default_nettype none

// Decoder state and the one-step decode of a held item into a command.
module trd_core #(
  parameter int unsigned TILE_COLUMNS = 256,
  parameter int unsigned COLUMN_BYTES = 128
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  wire trd_pkg::item_t item_i,
  output trd_pkg::cmd_t       cmd_o
);

  localparam int unsigned COL_W = $clog2(TILE_COLUMNS + 1);
  localparam int unsigned ROW_W = $clog2(COLUMN_BYTES);
  localparam int unsigned FSW   = trd_pkg::FILL_SUM_W;
  localparam int unsigned CSW   = trd_pkg::COPY_SUM_W;

  logic [COL_W-1:0] cur_column_q, cur_column_d;
  logic [ROW_W-1:0] cur_row_q, cur_row_d;
  logic [7:0]       run_pending_q, run_pending_d;
  logic             copy_pending_q, copy_pending_d;

  logic [7:0]                    b;
  logic                          fill_req;
  logic [7:0]                    fill_len;
  logic [7:0]                    fill_val;
  logic [FSW-1:0]                fill_sum;
  logic [CSW-1:0]                copy_sum;
  logic [trd_pkg::CUR_COL_W-1:0] col_ext;
  logic [6:0]                    row_ext;

  assign b        = item_i.code_byte;
  assign fill_sum = FSW'(cur_row_q) + FSW'(fill_len);
  assign copy_sum = CSW'(cur_column_q) + CSW'(b);
  assign col_ext  = trd_pkg::CUR_COL_W'(cur_column_q);
  assign row_ext  = 7'(cur_row_q);

  always_comb begin
    cur_column_d   = cur_column_q;
    cur_row_d      = cur_row_q;
    run_pending_d  = run_pending_q;
    copy_pending_d = copy_pending_q;
    cmd_o          = '0;
    cmd_o.kind     = trd_pkg::KIND_NONE;
    fill_req       = 1'b0;
    fill_len       = 8'd1;
    fill_val       = b;

    if (item_i.mode) begin
      cur_column_d   = '0;
      cur_row_d      = '0;
      run_pending_d  = '0;
      copy_pending_d = 1'b0;
    end else if (copy_pending_q) begin
      if (cur_column_q == '0 || cur_row_q != '0 || copy_sum > CSW'(TILE_COLUMNS)) begin
        cmd_o.kind   = trd_pkg::KIND_ERROR;
        cmd_o.column = col_ext[7:0];
        cmd_o.row    = row_ext;
        cmd_o.length = b;
      end else begin
        cmd_o.kind     = trd_pkg::KIND_COPY;
        cmd_o.column   = col_ext[7:0];
        cmd_o.length   = b;
        cur_column_d   = copy_sum[COL_W-1:0];
        copy_pending_d = 1'b0;
      end
    end else if (run_pending_q != '0) begin
      fill_req = 1'b1;
      fill_len = run_pending_q;
    end else if (b == trd_pkg::COPY_CODE) begin
      copy_pending_d = 1'b1;
    end else if (b[0]) begin
      run_pending_d = {1'b0, b[7:1]} + trd_pkg::RUN_BIAS;
    end else if (b[trd_pkg::DOUBLE_BIT]) begin
      fill_req = 1'b1;
      fill_len = 8'd2;
      fill_val = b & ~(8'd1 << trd_pkg::DOUBLE_BIT);
    end else begin
      fill_req = 1'b1;
    end

    if (fill_req) begin
      cmd_o.column = col_ext[7:0];
      cmd_o.row    = row_ext;
      cmd_o.length = fill_len;
      if (cur_column_q >= COL_W'(TILE_COLUMNS) || fill_sum > FSW'(COLUMN_BYTES)) begin
        cmd_o.kind = trd_pkg::KIND_ERROR;
      end else begin
        cmd_o.kind       = trd_pkg::KIND_FILL;
        cmd_o.fill_value = fill_val;
        run_pending_d    = '0;
        // A fill that ends the column moves on to the top of the next one.
        if (fill_sum == FSW'(COLUMN_BYTES)) begin
          cur_row_d    = '0;
          cur_column_d = cur_column_q + COL_W'(1);
        end else begin
          cur_row_d = fill_sum[ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_column_q   <= '0;
      cur_row_q      <= '0;
      run_pending_q  <= '0;
      copy_pending_q <= 1'b0;
    end else if (step_i) begin
      cur_column_q   <= cur_column_d;
      cur_row_q      <= cur_row_d;
      run_pending_q  <= run_pending_d;
      copy_pending_q <= copy_pending_d;
    end
  end

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.mode |=> cur_column_q == '0 && cur_row_q == '0 &&
      run_pending_q == '0 && !copy_pending_q)
    else $error("start item did not clear the decoder state");

  a_error_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cmd_o.kind == trd_pkg::KIND_ERROR |=> $stable(cur_column_q) &&
      $stable(cur_row_q) && $stable(run_pending_q) && $stable(copy_pending_q))
    else $error("error command changed the decoder state");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FSW'(cur_row_q) < FSW'(COLUMN_BYTES) && cur_column_q <= COL_W'(TILE_COLUMNS))
    else $error("position outside the tile");

  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(copy_pending_q && run_pending_q != '0))
    else $error("copy and run armed together");

endmodule

`default_nettype wire

// ===== rtl/core/tile_rle_decoder.sv =====
`default_nettype none

// Channel     Dir  tdata                                    tuser
// s_axis      in   code_byte[7:0]                           mode
// m_axis      out  column, row, length, fill_value, 0 pad   kind[1:0]
//
// Every accepted item gives exactly one command, one item per cycle sustained
// while the output does not stall. An item is held in the input register and
// is then decoded into the output register.
// Reset clears the position, the armed run and copy modes and both valid flags.
// A stalled output holds its command; the input register keeps taking a new
// item in the same cycle the held command leaves.
module tile_rle_decoder #(
  parameter int unsigned TILE_COLUMNS = 256,
  parameter int unsigned COLUMN_BYTES = 128
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] code_byte
  input  wire         s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] column, [14:8] row, [22:15] length,
                                        // [30:23] fill_value, [31] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] kind
);

  trd_pkg::item_t in_item;
  trd_pkg::item_t held_item;
  trd_pkg::cmd_t  cmd;
  trd_pkg::cmd_t  out_q;
  logic           held_valid;
  logic           step;
  logic           out_valid_q, out_valid_d;

  assign in_item.mode      = s_axis_tuser_i;
  assign in_item.code_byte = s_axis_tdata_i;

  // The held item is decoded whenever the output register is free or being drained.
  assign step = held_valid && (!out_valid_q || m_axis_tready_i);

  trd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (step),
    .item_o  (held_item)
  );

  trd_core #(
    .TILE_COLUMNS (TILE_COLUMNS),
    .COLUMN_BYTES (COLUMN_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (held_item),
    .cmd_o  (cmd)
  );

  assign out_valid_d = step || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= cmd;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {1'b0, out_q.fill_value, out_q.length, out_q.row, out_q.column};

endmodule

`default_nettype wire

// ===== verif/tile_rle_decoder_tb.sv =====
module tile_rle_decoder_tb;

  localparam int unsigned TileCols   = 256;
  localparam int unsigned ColBytes   = 128;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned RandItems  = 1700;
  localparam int unsigned DrainWait  = 20;
  localparam logic        MODE_DATA  = 1'b0;
  localparam logic        MODE_START = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [31:0] m_data;
  wire  [1:0]  m_user;

  trd_pkg::item_t code_queue[$];
  trd_pkg::cmd_t  expected_cmds[$];
  int unsigned    error_count = 0;

  // Shadow of the decoder position and armed modes.
  int unsigned tile_col = 0;
  int unsigned tile_row = 0;
  int unsigned run_len = 0;
  bit          copy_armed = 1'b0;

  tile_rle_decoder #(
    .TILE_COLUMNS (TileCols),
    .COLUMN_BYTES (ColBytes)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A fill is checked against the tile bounds; on overrun the state stays as is.
  function automatic trd_pkg::cmd_t fill_cmd(int unsigned len, logic [7:0] value);
    trd_pkg::cmd_t c;
    c = '0;
    c.column = tile_col[7:0];
    c.row    = tile_row[6:0];
    c.length = len[7:0];
    if (tile_col >= TileCols || tile_row + len > ColBytes) begin
      c.kind = trd_pkg::KIND_ERROR;
    end else begin
      c.kind       = trd_pkg::KIND_FILL;
      c.fill_value = value;
      tile_row += len;
      if (tile_row >= ColBytes) begin
        tile_row = 0;
        tile_col += 1;
      end
      run_len = 0;
    end
    return c;
  endfunction

  function automatic trd_pkg::cmd_t decode_code(trd_pkg::item_t it);
    trd_pkg::cmd_t c;
    logic [7:0]    b;
    c = '0;
    c.kind = trd_pkg::KIND_NONE;
    b = it.code_byte;
    if (it.mode == MODE_START) begin
      tile_col   = 0;
      tile_row   = 0;
      run_len    = 0;
      copy_armed = 1'b0;
    end else if (copy_armed) begin
      // The copy count byte: needs a previous column and a column boundary.
      c.column = tile_col[7:0];
      c.length = b;
      if (tile_col == 0 || tile_row != 0 || tile_col + b > TileCols) begin
        c.kind = trd_pkg::KIND_ERROR;
        c.row  = tile_row[6:0];
      end else begin
        c.kind = trd_pkg::KIND_COPY;
        tile_col += b;
        copy_armed = 1'b0;
      end
    end else if (run_len != 0) begin
      c = fill_cmd(run_len, b);
    end else if (b == trd_pkg::COPY_CODE) begin
      copy_armed = 1'b1;
    end else if (b[0]) begin
      run_len = (b >> 1) + trd_pkg::RUN_BIAS;
    end else if (b[trd_pkg::DOUBLE_BIT]) begin
      b[trd_pkg::DOUBLE_BIT] = 1'b0;
      c = fill_cmd(2, b);
    end else begin
      c = fill_cmd(1, b);
    end
    return c;
  endfunction

  task automatic add_code(logic mode, logic [7:0] b);
    trd_pkg::item_t it;
    it.mode      = mode;
    it.code_byte = b;
    code_queue.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    trd_pkg::item_t sent;
    trd_pkg::item_t next_item;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        sent.mode      = s_user;
        sent.code_byte = s_data;
        expected_cmds.push_back(decode_code(sent));
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (code_queue.size() > 0) begin
          next_item = code_queue.pop_front();
          s_valid <= 1'b1;
          s_user  <= next_item.mode;
          s_data  <= next_item.code_byte;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: m_ready steps through the bits of an 8-bit stall pattern, and the pattern is redrawn periodically.
  // Bit 0 is always set so the output never stalls for a whole pattern.
  logic [7:0]  stall_pattern = 8'hFF;
  int unsigned stall_phase = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_phase % 64 == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      m_ready <= stall_pattern[stall_phase % 8];
      stall_phase++;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    trd_pkg::cmd_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected command", {m_user, m_data[29:0]}, '0);
      end else begin
        want = expected_cmds.pop_front();
        check_field("kind", m_user, want.kind);
        check_field("column", m_data[7:0], want.column);
        check_field("row", m_data[14:8], want.row);
        check_field("length", m_data[22:15], want.length);
        check_field("fill_value", m_data[30:23], want.fill_value);
        check_field("pad", m_data[31], 1'b0);
      end
    end
  end

  // Watchdog: too many cycles without a handshake on either side.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout with %0d commands outstanding", expected_cmds.size());
        $display("FAIL tile_rle_decoder");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned drain;
    logic [7:0]  b;

    // Directed part. A copy at column 0 is an error whatever its count, and the
    // armed copy survives it, so the count 0 after it is a second copy attempt.
    add_code(MODE_START, 8'hFF);
    add_code(MODE_DATA, trd_pkg::COPY_CODE);
    add_code(MODE_DATA, 8'h05);
    add_code(MODE_DATA, 8'h00);
    add_code(MODE_START, 8'h00);
    // Single byte, doubled byte and even byte without the double bit.
    add_code(MODE_DATA, 8'h00);
    add_code(MODE_DATA, 8'hFE);
    add_code(MODE_DATA, 8'hEE);
    // A full-column run from row 4 overruns the column.
    add_code(MODE_DATA, 8'hFD);
    add_code(MODE_DATA, 8'h55);
    add_code(MODE_START, 8'h80);
    // A full-column run fills column 0, then a copy of zero columns succeeds.
    add_code(MODE_DATA, 8'hFD);
    add_code(MODE_DATA, 8'hAB);
    add_code(MODE_DATA, trd_pkg::COPY_CODE);
    add_code(MODE_DATA, 8'h00);
    // A copy off row zero is an error.
    add_code(MODE_DATA, 8'h02);
    add_code(MODE_DATA, trd_pkg::COPY_CODE);
    add_code(MODE_DATA, 8'h03);
    add_code(MODE_START, 8'h7F);
    // Fill column 0, copy up to the full tile, then fill and copy past it.
    add_code(MODE_DATA, 8'hFD);
    add_code(MODE_DATA, 8'h11);
    add_code(MODE_DATA, trd_pkg::COPY_CODE);
    add_code(MODE_DATA, 8'hFF);
    add_code(MODE_DATA, 8'h04);
    add_code(MODE_DATA, trd_pkg::COPY_CODE);
    add_code(MODE_DATA, 8'h01);

    // Random part: mostly well-formed codes with random content, some noise.
    while (code_queue.size() < RandItems + 26) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        add_code(MODE_START, 8'($urandom));
      end else if (pick < 40) begin
        add_code(MODE_DATA, 8'($urandom) & 8'hFE);
      end else if (pick < 65) begin
        if ($urandom_range(0, 9) < 7) begin
          b = 8'($urandom_range(1, 15) * 2 + 1);
        end else begin
          b = 8'($urandom) | 8'h01;
          if (b == trd_pkg::COPY_CODE) begin
            b = 8'h03;
          end
        end
        add_code(MODE_DATA, b);
        add_code(MODE_DATA, 8'($urandom));
      end else if (pick < 80) begin
        add_code(MODE_DATA, trd_pkg::COPY_CODE);
        if ($urandom_range(0, 3) != 0) begin
          add_code(MODE_DATA, 8'($urandom_range(0, 6)));
        end else begin
          add_code(MODE_DATA, 8'($urandom));
        end
      end else begin
        add_code(MODE_DATA, 8'($urandom));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every item is taken and every command has come back.
    while (code_queue.size() > 0 || s_valid) begin
      @(posedge clk_i);
    end
    while (expected_cmds.size() > 0) begin
      @(posedge clk_i);
    end
    for (drain = 0; drain < DrainWait; drain++) begin
      @(posedge clk_i);
    end

    if (error_count == 0) begin
      $display("PASS tile_rle_decoder");
    end else begin
      $display("FAIL tile_rle_decoder");
    end
    $finish;
  end

endmodule
